[rtl/two_capture_frequency_meter_defines.svh]
// Assertion macros shared by the frequency meter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TWO_CAPTURE_FREQUENCY_METER_DEFINES_SVH
`define TWO_CAPTURE_FREQUENCY_METER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, skipped while reset is high.
`define TCFM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcfm check failed");
// Check a property on every rising clock edge, reset included.
`define TCFM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tcfm check failed");
`else
`define TCFM_ASSERT(label, clk, rst, prop)
`define TCFM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/tcfm_pkg.sv]
// Shared types and constants for the two-capture frequency meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcfm_pkg;

   // Field widths
   localparam int COUNTER_WIDTH  = 16;
   localparam int OVERFLOW_WIDTH = 16;
   localparam int PERIOD_W       = COUNTER_WIDTH + OVERFLOW_WIDTH;
   localparam int FREQ_W         = 27;
   localparam int OPCODE_W       = 2;
   localparam int PHASE_W        = 2;

   // Reset value of the clock register
   localparam logic [FREQ_W-1:0] CLOCK_RESET = FREQ_W'(72000000);

   // Event codes
   localparam logic [OPCODE_W-1:0] OP_START    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_OVERFLOW = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CAPTURE  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE  = 2'd3;

   // Capture phases
   localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Divider: one quotient bit per cycle
   localparam int DIV_STEPS = FREQ_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic [COUNTER_WIDTH-1:0] capture_value;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic [PERIOD_W-1:0] period_ticks;
      logic [FREQ_W-1:0]   freq_hz;
      logic                result_valid;
      logic                error_flag;
   } rsp_type;

   // Classified work handed from front to back
   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic [PERIOD_W-1:0] period;
      logic                result_valid;
      logic                error_flag;
      logic                do_divide;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[rtl/tcfm_queue.sv]
// Two-entry job queue between the event front and the divide back.
// Depends on tcfm_pkg.
`timescale 1ns / 1ps

module tcfm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcfm_pkg::job_type  push_job,
   input  logic               pop,
   output tcfm_pkg::job_type  head_job,
   output tcfm_pkg::qstat_type status
);
   import tcfm_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/tcfm_front.sv]
// Event front: accepts items, keeps the capture state and classifies each
// item into a job for the back. Depends on tcfm_pkg.
`timescale 1ns / 1ps

module tcfm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tcfm_pkg::req_type   req_data,
   input  tcfm_pkg::qstat_type qstat,
   output logic                push,
   output tcfm_pkg::job_type   push_job
);
   import tcfm_pkg::*;

   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0]  first_ff, first_in;
   logic [COUNTER_WIDTH-1:0]  second_ff, second_in;
   logic [OVERFLOW_WIDTH-1:0] ovf_ff, ovf_in;
   logic                      sat_ff, sat_in;
   logic                      accept;
   logic                      compute_ok;
   logic [COUNTER_WIDTH-1:0]  diff;
   logic [PERIOD_W-1:0]       period;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;

   // Period from the two captures and the overflows between them
   assign diff       = second_ff - first_ff;
   assign period     = {ovf_ff, diff};
   assign compute_ok = (req_data.opcode == OP_COMPUTE) && (phase_ff == PH_DONE);

   // Next capture state
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ovf_in    = ovf_ff;
      sat_in    = sat_ff;
      unique case (req_data.opcode)
         OP_START: begin
            phase_in = PH_FIRST;
            ovf_in   = '0;
            sat_in   = 1'b0;
         end
         OP_OVERFLOW: begin
            if (phase_ff == PH_SECOND) begin
               if (&ovf_ff) begin
                  sat_in = 1'b1;
               end else begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end
         end
         OP_CAPTURE: begin
            if (phase_ff == PH_FIRST) begin
               first_in = req_data.capture_value;
               phase_in = PH_SECOND;
            end else if (phase_ff == PH_SECOND) begin
               second_in = req_data.capture_value;
               phase_in  = PH_DONE;
            end
         end
         OP_COMPUTE: begin
            if (phase_ff == PH_DONE) begin
               phase_in = PH_IDLE;
               ovf_in   = '0;
               sat_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Classify the item for the back
   always_comb begin
      push_job.phase        = phase_in;
      push_job.period       = compute_ok ? period : '0;
      push_job.result_valid = compute_ok;
      push_job.error_flag   = compute_ok && (sat_ff || (period == '0));
      push_job.do_divide    = compute_ok && (period != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         first_ff  <= '0;
         second_ff <= '0;
         ovf_ff    <= '0;
         sat_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ovf_ff    <= ovf_in;
         sat_ff    <= sat_in;
      end
   end

endmodule

[rtl/tcfm_back.sv]
// Divide back: takes jobs from the queue, runs the restoring divide for
// frequency and holds the result register. Depends on tcfm_pkg.
`timescale 1ns / 1ps
`include "two_capture_frequency_meter_defines.svh"

module tcfm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [tcfm_pkg::FREQ_W-1:0] clock_hz,
   input  tcfm_pkg::job_type   head_job,
   input  tcfm_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tcfm_pkg::rsp_type   rsp_data
);
   import tcfm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   job_type             job_ff, job_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0]   quo_ff, quo_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                out_free;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   trial;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // One restoring step
   assign shifted = {rem_ff, quo_ff[FREQ_W-1]};
   assign trial   = shifted - {1'b0, job_ff.period};

   // Sequence jobs through the divider and into the output register
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               if (head_job.do_divide) begin
                  pop      = 1'b1;
                  job_in   = head_job;
                  rem_in   = '0;
                  quo_in   = clock_hz;
                  cnt_in   = '0;
                  state_in = ST_DIVIDE;
               end else if (out_free) begin
                  pop                 = 1'b1;
                  rsp_valid_in        = 1'b1;
                  rsp_in.phase        = head_job.phase;
                  rsp_in.period_ticks = head_job.period;
                  rsp_in.freq_hz      = '0;
                  rsp_in.result_valid = head_job.result_valid;
                  rsp_in.error_flag   = head_job.error_flag;
               end
            end
         end
         ST_DIVIDE: begin
            if (!trial[PERIOD_W]) begin
               rem_in = trial[PERIOD_W-1:0];
               quo_in = {quo_ff[FREQ_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[PERIOD_W-1:0];
               quo_in = {quo_ff[FREQ_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.phase        = job_ff.phase;
               rsp_in.period_ticks = job_ff.period;
               rsp_in.freq_hz      = quo_ff;
               rsp_in.result_valid = job_ff.result_valid;
               rsp_in.error_flag   = job_ff.error_flag;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCFM_ASSERT(a_pop_not_empty, clock, reset, pop |-> !qstat.empty)
   `TCFM_ASSERT(a_div_count_bound, clock, reset,
      (state_ff == ST_DIVIDE) |-> (cnt_ff <= DCNT_W'(DIV_STEPS - 1)))
   `TCFM_ASSERT(a_valid_ends_idle, clock, reset,
      (rsp_valid_ff && rsp_ff.result_valid) |-> (rsp_ff.phase == PH_IDLE))
   `TCFM_ASSERT(a_zero_period_err, clock, reset,
      (rsp_valid_ff && rsp_ff.result_valid && (rsp_ff.period_ticks == '0))
      |-> (rsp_ff.error_flag && (rsp_ff.freq_hz == '0)))

endmodule

[rtl/two_capture_frequency_meter.sv]
// Two-capture frequency meter. Each accepted item is queued and the back
// registers its result from the queue head; a valid compute first runs the
// one-bit-per-cycle divide (27 steps). Throughput: one item per cycle while
// the queue has room and the result is not stalled; a divide holds the back
// while the 2-entry queue keeps taking items. Reset (synchronous, active high):
// idle phase, counts cleared, clock register 72000000, queue and output empty.
`timescale 1ns / 1ps

module two_capture_frequency_meter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcfm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcfm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [tcfm_pkg::FREQ_W-1:0] csr_data
);
   import tcfm_pkg::*;

   logic [FREQ_W-1:0] clock_hz_ff;
   logic              push;
   logic              pop;
   job_type           push_job;
   job_type           head_job;
   qstat_type         qstat;

   // Clock register, written any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else if (csr_valid && csr_ready) begin
         clock_hz_ff <= csr_data;
      end
   end

   tcfm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_job  (push_job)
   );

   tcfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (qstat)
   );

   tcfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clock_hz  (clock_hz_ff),
      .head_job  (head_job),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/freq_meter_checker.sv]
// Checker for the two-capture frequency meter: watches the item, result and register channels.
// Predicts every result from its own copy of the measurement state; depends on tcfm_pkg.
`timescale 1ns / 1ps

module freq_meter_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  tcfm_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  tcfm_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [tcfm_pkg::FREQ_W-1:0] csr_data,
   output int                          mismatches,
   output int                          outstanding
);
   import tcfm_pkg::*;

   // Shadow of the clock register and of the capture state
   logic [FREQ_W-1:0]         clock_setting;
   logic [PHASE_W-1:0]        capture_phase;
   logic [COUNTER_WIDTH-1:0]  first_capture;
   logic [COUNTER_WIDTH-1:0]  second_capture;
   logic [OVERFLOW_WIDTH-1:0] wrap_count;
   logic                      wrap_saturated;

   rsp_type expected_readings[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Advance the shadow state by one item and return the reading it produces
   function automatic rsp_type predict_reading(input req_type item);
      rsp_type                  reading;
      logic [COUNTER_WIDTH-1:0] span_low;
      logic [PERIOD_W-1:0]      span;
      reading = '0;
      case (item.opcode)
         OP_START: begin
            capture_phase  = PH_FIRST;
            wrap_count     = '0;
            wrap_saturated = 1'b0;
         end
         OP_OVERFLOW: begin
            // count wraps only between the two captures
            if (capture_phase == PH_SECOND) begin
               if (wrap_count == '1)
                  wrap_saturated = 1'b1;
               else
                  wrap_count = wrap_count + 1'b1;
            end
         end
         OP_CAPTURE: begin
            if (capture_phase == PH_FIRST) begin
               first_capture = item.capture_value;
               capture_phase = PH_SECOND;
            end else if (capture_phase == PH_SECOND) begin
               second_capture = item.capture_value;
               capture_phase  = PH_DONE;
            end
         end
         default: begin
            if (capture_phase == PH_DONE) begin
               span_low             = second_capture - first_capture;
               span                 = {wrap_count, span_low};
               reading.result_valid = 1'b1;
               reading.error_flag   = wrap_saturated;
               reading.period_ticks = span;
               if (span == '0)
                  reading.error_flag = 1'b1;
               else
                  reading.freq_hz = FREQ_W'(PERIOD_W'(clock_setting) / span);
               capture_phase  = PH_IDLE;
               wrap_count     = '0;
               wrap_saturated = 1'b0;
            end
         end
      endcase
      reading.phase = capture_phase;
      return reading;
   endfunction

   // Compare one field and report the first few misses
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $realtime, field, want, want, got, got);
      end
   endtask

   // Track accepted items, register writes and results on each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clock_setting  = CLOCK_RESET;
         capture_phase  = PH_IDLE;
         first_capture  = '0;
         second_capture = '0;
         wrap_count     = '0;
         wrap_saturated = 1'b0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready)
            clock_setting = csr_data;
         if (req_valid && !req_stall)
            expected_readings.push_back(predict_reading(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected, phase %0d period %0d",
                           $realtime, rsp_data.phase, rsp_data.period_ticks);
            end else begin
               want = expected_readings.pop_front();
               check_field("phase", 32'(want.phase), 32'(rsp_data.phase));
               check_field("period_ticks", want.period_ticks, rsp_data.period_ticks);
               check_field("freq_hz", 32'(want.freq_hz), 32'(rsp_data.freq_hz));
               check_field("result_valid", 32'(want.result_valid),
                           32'(rsp_data.result_valid));
               check_field("error_flag", 32'(want.error_flag), 32'(rsp_data.error_flag));
            end
         end
      end
      outstanding <= expected_readings.size();
   end

endmodule

[tb/tb.sv]
// Top of the frequency meter testbench: clock, reset, stimulus, register writes and verdict.
// Depends on tcfm_pkg, the two_capture_frequency_meter RTL and freq_meter_checker.
`timescale 1ns / 1ps

module tb;
   import tcfm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 40;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [FREQ_W-1:0] csr_data;

   int mismatches;
   int outstanding;
   int items_sent;

   // Idling controls for the two sides
   bit req_gaps;
   bit rsp_jitter;
   bit hold_request;
   int hold_left;
   int stall_left;

   two_capture_frequency_meter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   freq_meter_checker checker_0 (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Drive result stall: a long hold on request, else random bursts
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 200;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_jitter && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one item; return at the edge that accepts it
   task automatic send(input logic [OPCODE_W-1:0] op, input logic [COUNTER_WIDTH-1:0] value);
      req_type item;
      item.opcode        = op;
      item.capture_value = value;
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the clock register while the block is idle
   task automatic write_clock(input logic [FREQ_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random measurements with noise: mostly full start/capture/capture/compute runs
   task automatic run_measurements(input int quota);
      int                       stop_at;
      int                       wraps;
      logic [COUNTER_WIDTH-1:0] first_value;
      logic [COUNTER_WIDTH-1:0] second_value;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            first_value = COUNTER_WIDTH'($urandom);
            case ($urandom_range(0, 3))
               0:       second_value = first_value;
               1:       second_value = first_value + COUNTER_WIDTH'($urandom_range(1, 40));
               default: second_value = COUNTER_WIDTH'($urandom);
            endcase
            send(OP_START, COUNTER_WIDTH'($urandom));
            if ($urandom_range(0, 5) == 0)
               send(OPCODE_W'($urandom), COUNTER_WIDTH'($urandom));
            send(OP_CAPTURE, first_value);
            wraps = ($urandom_range(0, 4) == 0) ? int'($urandom_range(4, 30))
                                                : int'($urandom_range(0, 3));
            repeat (wraps) send(OP_OVERFLOW, COUNTER_WIDTH'($urandom));
            if ($urandom_range(0, 7) == 0)
               send(OP_COMPUTE, COUNTER_WIDTH'($urandom));
            send(OP_CAPTURE, second_value);
            if ($urandom_range(0, 7) == 0)
               send(OP_CAPTURE, COUNTER_WIDTH'($urandom));
            if ($urandom_range(0, 9) != 0)
               send(OP_COMPUTE, COUNTER_WIDTH'($urandom));
         end else begin
            send(OPCODE_W'($urandom), COUNTER_WIDTH'($urandom));
         end
      end
   endtask

   // End the run if it hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      items_sent   = 0;
      req_gaps     = 1'b1;
      rsp_jitter   = 1'b1;
      hold_request = 1'b0;
      hold_left    = 0;
      stall_left   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: events out of order, counted wraps, counter wrap, zero period
      send(OP_COMPUTE, 16'h0000);
      send(OP_OVERFLOW, 16'hFFFF);
      send(OP_CAPTURE, 16'h1234);
      send(OP_START, 16'hFFFF);
      send(OP_OVERFLOW, 16'h0000);
      send(OP_COMPUTE, 16'h5555);
      send(OP_CAPTURE, 16'h0000);
      send(OP_COMPUTE, 16'hAAAA);
      send(OP_OVERFLOW, 16'h0001);
      send(OP_CAPTURE, 16'hFFFF);
      send(OP_CAPTURE, 16'h4321);
      send(OP_OVERFLOW, 16'h0002);
      send(OP_COMPUTE, 16'h0000);
      send(OP_START, 16'h0000);
      send(OP_CAPTURE, 16'hFFFF);
      send(OP_START, 16'h0000);
      send(OP_CAPTURE, 16'hFFFF);
      send(OP_CAPTURE, 16'h0001);
      send(OP_COMPUTE, 16'hFFFF);
      send(OP_START, 16'h0000);
      send(OP_CAPTURE, 16'h8000);
      send(OP_CAPTURE, 16'h8000);
      send(OP_COMPUTE, 16'h0000);
      send(OP_COMPUTE, 16'h0000);

      // Many counted wraps at the widest register value, without idling
      req_gaps   = 1'b0;
      rsp_jitter = 1'b0;
      write_clock('1);
      send(OP_START, 16'h0000);
      send(OP_CAPTURE, 16'h0000);
      repeat (40) send(OP_OVERFLOW, COUNTER_WIDTH'($urandom));
      send(OP_CAPTURE, 16'hFFFF);
      send(OP_COMPUTE, 16'h0000);

      // Random phases across register settings; hold the results long at first
      req_gaps   = 1'b1;
      rsp_jitter = 1'b1;
      write_clock(FREQ_W'(100000000));
      hold_request = 1'b1;
      run_measurements(55);
      write_clock(FREQ_W'(1));
      run_measurements(45);
      write_clock('0);
      run_measurements(45);
      req_gaps   = 1'($urandom_range(0, 1));
      rsp_jitter = 1'($urandom_range(0, 1));
      write_clock(FREQ_W'($urandom_range(1, 100000000)));
      run_measurements(55);
      req_gaps   = 1'b1;
      rsp_jitter = 1'b1;
      write_clock('1);
      run_measurements(55);

      // Last stretch with no idling on either side
      req_gaps   = 1'b0;
      rsp_jitter = 1'b0;
      write_clock(CLOCK_RESET);
      run_measurements(55);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
